// File: hdl/hle_pkg.sv
// shared constants and codes for the heartbeat leader election block
package hle_pkg;

    localparam int MAX_PEERS = 16;
    localparam int FILL_W    = $clog2(MAX_PEERS + 1);
    localparam int IDX_W     = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;

    localparam int ID_W    = 32;
    localparam int TIME_W  = 64;
    localparam int TMO_W   = 32;
    localparam int CMD_W   = 2;
    localparam int ROLE_W  = 2;
    localparam int COUNT_W = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ELECT     = 2'd2;

    localparam logic [ROLE_W-1:0] ROLE_UNKNOWN = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_MASTER  = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_SLAVE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SELF_ID = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd1;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 32'd3000;

endpackage

// File: hdl/heartbeat_leader_election.sv
// heartbeat leader election: peer table, timeout sweep and highest-id election
//
// Input channel (i_in_valid / o_in_ready) carries one command per transfer:
// heartbeat from i_peer_id at i_time_ms, timeout check at time i_time_ms, or
// election. Each command yields exactly one result on the output channel
// (o_out_valid / i_out_ready). Registers self_id and timeout_ms are written
// through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only
// while no command is in flight, the block itself does not enforce it. One
// sequencer walks the peer table one slot per cycle, with id compares and a
// single 64-bit elapsed-time subtract and compare. A heartbeat walks until
// it finds i_peer_id or appends it at the end (dropped if the table is full);
// a timeout check sweeps every filled slot and then elects if a peer expired;
// an election walks every filled slot. A new command is taken only while the
// sequencer is idle, the cycle after the previous result is loaded, so none
// is taken before the previous one completes; it may be taken while the
// previous result still waits in the output register. If the receiver stalls,
// the finished command waits in ST_FIN until the output register frees up.
// Synchronous active-low reset clears the active bits, table fill, role
// (unknown), elected id, self_id to 0 and timeout_ms to 3000; no sweep needed.
module heartbeat_leader_election
    import hle_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [ID_W-1:0]       i_peer_id,
    input  logic [TIME_W-1:0]     i_time_ms,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [ROLE_W-1:0]     o_my_role,
    output logic [ID_W-1:0]       o_leader_id,
    output logic                  o_role_changed,
    output logic                  o_peer_dropped,
    output logic                  o_peer_expired,
    output logic [COUNT_W-1:0]    o_active_count,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
    localparam logic [ST_W-1:0] ST_HB   = 3'd1;
    localparam logic [ST_W-1:0] ST_TO   = 3'd2;
    localparam logic [ST_W-1:0] ST_EL   = 3'd3;
    localparam logic [ST_W-1:0] ST_FIN  = 3'd4;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(MAX_PEERS);

    logic [ST_W-1:0]    r_state, n_state;
    logic [FILL_W-1:0]  r_idx, n_idx;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [FILL_W-1:0]  r_act, n_act;
    logic [MAX_PEERS-1:0] r_active, n_active;
    logic [ID_W-1:0]    r_self, n_self;
    logic [TMO_W-1:0]   r_tmo, n_tmo;
    logic [ROLE_W-1:0]  r_own_role, n_own_role;
    logic [ID_W-1:0]    r_elected, n_elected;
    logic [ID_W-1:0]    r_pid, n_pid;
    logic [TIME_W-1:0]  r_now, n_now;
    logic [ID_W-1:0]    r_best, n_best;
    logic               r_changed, n_changed;
    logic               r_dropped, n_dropped;
    logic               r_expired, n_expired;

    logic               r_out_valid, n_out_valid;
    logic [ROLE_W-1:0]  r_out_role, n_out_role;
    logic [ID_W-1:0]    r_out_leader, n_out_leader;
    logic               r_out_changed, n_out_changed;
    logic               r_out_dropped, n_out_dropped;
    logic               r_out_expired, n_out_expired;
    logic [COUNT_W-1:0] r_out_count, n_out_count;

    logic [ID_W-1:0]    mem_ids  [MAX_PEERS];
    logic [TIME_W-1:0]  mem_seen [MAX_PEERS];
    logic [ID_W-1:0]    r_rd_id;
    logic [TIME_W-1:0]  r_rd_seen;

    logic [IDX_W-1:0]   w_addr;
    logic [IDX_W-1:0]   w_rd_addr;
    logic               w_we_seen;
    logic               w_we_id;
    logic [TIME_W-1:0]  w_elapsed;
    logic               w_tmo_hit;
    logic               w_at_end;
    logic               w_in_xfer;
    logic [31:0]        w_count_ext;

    assign w_addr      = r_idx[IDX_W-1:0];
    assign w_rd_addr   = n_idx[IDX_W-1:0];
    assign w_elapsed   = r_now - r_rd_seen;
    assign w_tmo_hit   = w_elapsed > {{(TIME_W-TMO_W){1'b0}}, r_tmo};
    assign w_at_end    = (r_idx == r_fill);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_count_ext = 32'(r_act) + 32'd1;

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_my_role      = r_out_role;
    assign o_leader_id    = r_out_leader;
    assign o_role_changed = r_out_changed;
    assign o_peer_dropped = r_out_dropped;
    assign o_peer_expired = r_out_expired;
    assign o_active_count = r_out_count;

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_fill        = r_fill;
        n_act         = r_act;
        n_active      = r_active;
        n_self        = r_self;
        n_tmo         = r_tmo;
        n_own_role    = r_own_role;
        n_elected     = r_elected;
        n_pid         = r_pid;
        n_now         = r_now;
        n_best        = r_best;
        n_changed     = r_changed;
        n_dropped     = r_dropped;
        n_expired     = r_expired;
        n_out_valid   = r_out_valid;
        n_out_role    = r_out_role;
        n_out_leader  = r_out_leader;
        n_out_changed = r_out_changed;
        n_out_dropped = r_out_dropped;
        n_out_expired = r_out_expired;
        n_out_count   = r_out_count;
        w_we_seen     = 1'b0;
        w_we_id       = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SELF_ID: n_self = i_cfg_data[ID_W-1:0];
                REG_TIMEOUT: n_tmo  = i_cfg_data[TMO_W-1:0];
                default: ;
            endcase
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_pid     = i_peer_id;
                    n_now     = i_time_ms;
                    n_idx     = '0;
                    n_changed = 1'b0;
                    n_dropped = 1'b0;
                    n_expired = 1'b0;
                    case (i_cmd)
                        CMD_HEARTBEAT: n_state = ST_HB;
                        CMD_TIMEOUT:   n_state = ST_TO;
                        CMD_ELECT: begin
                            n_best  = r_self;
                            n_state = ST_EL;
                        end
                        default: n_state = ST_FIN;
                    endcase
                end
            end
            ST_HB: begin
                if (w_at_end) begin
                    if (r_fill == FILL_FULL) begin
                        n_dropped = 1'b1;
                    end else begin
                        // append in the first free slot
                        w_we_id          = 1'b1;
                        w_we_seen        = 1'b1;
                        n_active[w_addr] = 1'b1;
                        n_act            = r_act + 1'b1;
                        n_fill           = r_fill + 1'b1;
                    end
                    n_state = ST_FIN;
                end else if (r_rd_id == r_pid) begin
                    w_we_seen        = 1'b1;
                    n_active[w_addr] = 1'b1;
                    if (!r_active[w_addr]) begin
                        n_act = r_act + 1'b1;
                    end
                    n_state = ST_FIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_TO: begin
                if (w_at_end) begin
                    if (r_expired) begin
                        n_best  = r_self;
                        n_idx   = '0;
                        n_state = ST_EL;
                    end else begin
                        n_state = ST_FIN;
                    end
                end else begin
                    if (r_active[w_addr] && w_tmo_hit) begin
                        n_active[w_addr] = 1'b0;
                        n_act            = r_act - 1'b1;
                        n_expired        = 1'b1;
                    end
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_EL: begin
                if (w_at_end) begin
                    n_elected  = r_best;
                    n_own_role = (r_best == r_self) ? ROLE_MASTER : ROLE_SLAVE;
                    n_changed  = (n_own_role != r_own_role);
                    n_state    = ST_FIN;
                end else begin
                    if (r_active[w_addr] && (r_rd_id > r_best)) begin
                        n_best = r_rd_id;
                    end
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_role    = r_own_role;
                    n_out_leader  = r_elected;
                    n_out_changed = r_changed;
                    n_out_dropped = r_dropped;
                    n_out_expired = r_expired;
                    n_out_count   = (w_count_ext > 32'(COUNT_MAX)) ? COUNT_MAX
                                                                   : w_count_ext[COUNT_W-1:0];
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_fill      <= '0;
            r_act       <= '0;
            r_active    <= '0;
            r_self      <= '0;
            r_tmo       <= TIMEOUT_RESET;
            r_own_role  <= ROLE_UNKNOWN;
            r_elected   <= '0;
            r_changed   <= 1'b0;
            r_dropped   <= 1'b0;
            r_expired   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_fill      <= n_fill;
            r_act       <= n_act;
            r_active    <= n_active;
            r_self      <= n_self;
            r_tmo       <= n_tmo;
            r_own_role  <= n_own_role;
            r_elected   <= n_elected;
            r_changed   <= n_changed;
            r_dropped   <= n_dropped;
            r_expired   <= n_expired;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pid         <= n_pid;
        r_now         <= n_now;
        r_best        <= n_best;
        r_out_role    <= n_out_role;
        r_out_leader  <= n_out_leader;
        r_out_changed <= n_out_changed;
        r_out_dropped <= n_out_dropped;
        r_out_expired <= n_out_expired;
        r_out_count   <= n_out_count;
    end

    // peer table, read address is the slot of the next cycle
    always_ff @(posedge i_clk) begin
        if (w_we_id) begin
            mem_ids[w_addr] <= r_pid;
        end
        if (w_we_seen) begin
            mem_seen[w_addr] <= r_now;
        end
        r_rd_id   <= mem_ids[w_rd_addr];
        r_rd_seen <= mem_seen[w_rd_addr];
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("peer table fill beyond capacity");

    a_act_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act <= r_fill)
        else $error("active peer count exceeds table fill");

    a_change_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_role_changed |-> o_my_role != ROLE_UNKNOWN)
        else $error("role change reported with unknown role");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_peer_dropped |-> r_fill == FILL_FULL)
        else $error("peer dropped while table not full");

    a_busy_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && (i_cmd == CMD_HEARTBEAT) |=> r_state == ST_HB && r_idx == '0)
        else $error("heartbeat transfer did not start table walk");

endmodule
